>>> hw/rtl/strm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_pkg
// Shared types and constants of the switch to relay mapper: entry layout,
// operation and mode codes, control state and the update request/response.
// ----------------------------------------------------------------------------
package strm_pkg;

	// table size and index width
	localparam int NUM_ENTRIES = 32;
	localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	// toggle window after reset, in ms
	localparam logic [15:0] WINDOW_RESET = 16'd300;

	// cloud command codes
	localparam logic [1:0] CLOUD_IDLE = 2'd0;
	localparam logic [1:0] CLOUD_ON   = 2'd1;
	localparam logic [1:0] CLOUD_OFF  = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_EVENT = 2'd1,
		OP_CLOUD = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_DOUBLE = 2'd1,
		MODE_DUAL   = 2'd2,
		MODE_OFF    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD_P,
		ST_RD_S,
		ST_WR_S
	} state_t;

	// one table entry
	typedef struct packed {
		mode_t       mode;
		logic [4:0]  primary;
		logic [4:0]  secondary;
		logic [1:0]  cloud;
		logic        prev;
		logic        level;
		logic        count;
		logic        stamp_valid;
		logic [31:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one input item, as held during its processing
	typedef struct packed {
		op_t         op;
		logic [4:0]  pin;
		logic        switch_level;
		mode_t       output_mode;
		logic [4:0]  primary_pin;
		logic [4:0]  secondary_pin;
		logic        toggle_count_init;
		logic [1:0]  cloud_command;
		logic [31:0] now_ms;
	} item_t;

	// update result for the addressed entry and its partner
	typedef struct packed {
		entry_t      new_e;
		entry_t      new_s;
		logic        status_changed;
		logic        partner_written;
		logic        partner_level;
	} step_rsp_t;

	// table index of a 5-bit pin number
	function automatic logic [IDX_W-1:0] to_idx(input logic [4:0] pin);
		return IDX_W'(pin);
	endfunction

	// pin number lies inside the table
	function automatic logic in_range(input logic [4:0] pin);
		return (32'(pin) < NUM_ENTRIES);
	endfunction

endpackage

>>> hw/rtl/strm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module strm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/strm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strm_step
// Update rule of one item: load, cloud command or switch event, applied to
// the addressed entry and its partner entry as read from the table.
// ----------------------------------------------------------------------------
module strm_step (
	input  strm_pkg::item_t     item,
	input  logic [15:0]         window,
	input  strm_pkg::entry_t    e,
	input  strm_pkg::entry_t    se,
	input  logic                self_hit,
	output strm_pkg::step_rsp_t rsp
);
	import strm_pkg::*;

	logic [1:0]  cc;
	logic        s;
	logic        go;
	logic        pl;
	logic        pw;
	logic        dbl;
	logic        cnt;
	logic [31:0] age;
	entry_t      ne;
	entry_t      nse;

	assign age = item.now_ms - e.stamp;

	// cloud code three is kept as idle
	assign cc = (item.cloud_command == 2'd3) ? CLOUD_IDLE : item.cloud_command;

	// cloud override, edge detection and mode rule
	always_comb begin
		ne  = e;
		go  = 1'b0;
		s   = item.switch_level;
		pl  = 1'b0;
		pw  = 1'b0;
		dbl = 1'b0;
		cnt = e.count;
		unique case (item.op)
			OP_LOAD: begin
				ne.mode        = item.output_mode;
				ne.primary     = item.primary_pin;
				ne.secondary   = item.secondary_pin;
				ne.count       = item.toggle_count_init;
				ne.cloud       = cc;
				ne.level       = item.switch_level;
				ne.prev        = 1'b0;
				ne.stamp       = '0;
				ne.stamp_valid = 1'b0;
			end
			OP_CLOUD: begin
				ne.cloud = cc;
			end
			OP_EVENT: begin
				if (e.mode != MODE_OFF) begin
					if (e.cloud != CLOUD_IDLE) begin
						if (e.prev != s) begin
							ne.cloud = CLOUD_IDLE;
							ne.prev  = s;
							go       = 1'b1;
						end else if (e.cloud == CLOUD_ON && e.level) begin
							go = 1'b0;
						end else if (e.cloud == CLOUD_OFF && !e.level) begin
							go = 1'b0;
						end else begin
							s  = (e.cloud == CLOUD_ON);
							go = 1'b1;
						end
					end else if (e.prev != s) begin
						ne.prev = s;
						go      = 1'b1;
					end
				end
				if (go) begin
					if (e.mode == MODE_SINGLE) begin
						ne.level = s;
					end else if (e.primary != e.secondary && in_range(e.secondary)) begin
						pw = 1'b1;
						if (e.mode == MODE_DOUBLE) begin
							ne.level = s;
							pl       = s;
							dbl      = 1'b1;
						end else begin
							// dual toggle: a missing or stale stamp clears the count
							if (!e.stamp_valid || age > {16'd0, window}) begin
								cnt = 1'b0;
							end
							ne.count = cnt;
							if (s) begin
								ne.level = 1'b1;
								pl       = cnt;
							end else begin
								ne.level = 1'b0;
								pl       = 1'b0;
								ne.count = !cnt;
								if (!cnt) begin
									ne.stamp       = item.now_ms;
									ne.stamp_valid = 1'b1;
								end
							end
						end
					end
				end
			end
			default: begin
				ne = e;
			end
		endcase

		// partner write, folded into the entry itself when it is its own partner
		nse = se;
		if (pw) begin
			if (self_hit) begin
				ne.level = pl;
				if (dbl) begin
					ne.count = 1'b0;
				end
			end else begin
				nse.level = pl;
				if (dbl) begin
					nse.count = 1'b0;
				end
			end
		end
	end

	// response fields
	always_comb begin
		rsp.new_e           = ne;
		rsp.new_s           = nse;
		rsp.status_changed  = go;
		rsp.partner_written = pw;
		if (!in_range(ne.secondary)) begin
			rsp.partner_level = 1'b0;
		end else if (self_hit) begin
			rsp.partner_level = ne.level;
		end else begin
			rsp.partner_level = nse.level;
		end
	end

endmodule

>>> hw/rtl/switch_to_relay_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// switch_to_relay_mapper_core
// Table of switch entries mapping switch events to relay output levels, with
// cloud override, double output and dual toggle modes.
// ----------------------------------------------------------------------------
//  channel | direction | data
//  s_*     | in        | item: tuser op, tdata fields
//  m_*     | out       | result: tdata fields
//  cfg_*   | in        | toggle window in ms
//
// An item is processed in order: read of the addressed entry, read of its partner,
// write of the entry and write of the partner, through the table's one read
// and one write port. The result waits in an output register; a stalled
// m_tready holds the last step, and an item is taken only when the previous
// one has finished. Reset clears the per-entry valid bits at once, so there is
// no clearing pass; the table is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module switch_to_relay_mapper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pin[4:0], switch_level[5], output_mode[7:6], primary_pin[12:8],
	// secondary_pin[17:13], toggle_count_init[18], cloud_command[20:19],
	// now_ms[52:21], zero fill[55:53]
	input  logic [55:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status_changed[0], out_level[1], partner_index[6:2], partner_level[7],
	// partner_written[8], zero fill[15:9]
	output logic [15:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	import strm_pkg::*;

	state_t            state_q;
	state_t            state_d;
	item_t             item_q;
	item_t             item_in;
	logic [15:0]       window_q;
	logic [NUM_ENTRIES-1:0] vld_q;
	logic              rd_vld_q;
	logic [IDX_W-1:0]  raddr;
	logic              re;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;
	logic [ENTRY_W-1:0] rdata;
	entry_t            rd_entry;
	entry_t            e_s1;
	logic [4:0]        sec_s1;
	logic              self_s1;
	logic              pin_ok_q;
	step_rsp_t         rsp;
	step_rsp_t         rsp_s2;
	logic              out_take;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;
	logic [4:0]        sec_next;

	// input unpacking
	assign item_in.op                = op_t'(s_tuser);
	assign item_in.pin               = s_tdata[4:0];
	assign item_in.switch_level      = s_tdata[5];
	assign item_in.output_mode       = mode_t'(s_tdata[7:6]);
	assign item_in.primary_pin       = s_tdata[12:8];
	assign item_in.secondary_pin     = s_tdata[17:13];
	assign item_in.toggle_count_init = s_tdata[18];
	assign item_in.cloud_command     = s_tdata[20:19];
	assign item_in.now_ms            = s_tdata[52:21];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// entries never written read as zero
	assign rd_entry = rd_vld_q ? entry_t'(rdata) : '0;

	// partner of the entry after this item
	assign sec_next = (item_q.op == OP_LOAD) ? item_q.secondary_pin : rd_entry.secondary;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	// table port control
	always_comb begin
		state_d  = state_q;
		re       = 1'b0;
		raddr    = to_idx(item_in.pin);
		we       = 1'b0;
		waddr    = to_idx(item_q.pin);
		wdata    = rsp_s2.new_e;
		out_take = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				raddr = to_idx(item_in.pin);
				if (s_tvalid) begin
					re      = 1'b1;
					state_d = ST_RD_P;
				end
			end
			ST_RD_P: begin
				raddr   = to_idx(sec_next);
				re      = 1'b1;
				state_d = ST_RD_S;
			end
			ST_RD_S: begin
				we      = pin_ok_q;
				waddr   = to_idx(item_q.pin);
				wdata   = rsp.new_e;
				state_d = ST_WR_S;
			end
			ST_WR_S: begin
				we    = rsp_s2.partner_written && !self_s1;
				waddr = to_idx(sec_s1);
				wdata = rsp_s2.new_s;
				if (!m_tvalid_q || m_tready) begin
					out_take = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// valid bits, one per entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	// item and pipeline payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			item_q   <= item_in;
			pin_ok_q <= in_range(item_in.pin);
		end
		if (state_q == ST_RD_P) begin
			e_s1    <= rd_entry;
			sec_s1  <= sec_next;
			self_s1 <= (sec_next == item_q.pin);
		end
		if (state_q == ST_RD_S) begin
			rsp_s2 <= rsp;
		end
	end

	strm_step u_step (
		.item     (item_q),
		.window   (window_q),
		.e        (e_s1),
		.se       (rd_entry),
		.self_hit (self_s1),
		.rsp      (rsp)
	);

	strm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			if (pin_ok_q) begin
				m_tdata_q <= {7'd0, rsp_s2.partner_written, rsp_s2.partner_level,
					rsp_s2.new_e.secondary, rsp_s2.new_e.level, rsp_s2.status_changed};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// no table write while a new request can be taken
	assert property (@(posedge clk) disable iff (!arst_n) we |-> !s_tready)
		else $error("table written while idle");

	// a result never appears the cycle after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result too early");

	// partner write only comes with an accepted change
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[8]) |-> m_tdata[0])
		else $error("partner written without change");

	// partner write never targets the addressed entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR_S && we) |-> (waddr != to_idx(item_q.pin)))
		else $error("partner write hits addressed entry");
`endif

endmodule
